// ===== hdl/dbl_pkg.sv =====
// Package for the depth buffer linearizer.
// Holds register indexes, reset values and default widths; no dependencies.
package dbl_pkg;

  // Default field widths.
  localparam int DefDepthBits = 24;
  localparam int DefDistBits  = 24;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CENTER = 2'd0,
    REG_HALF   = 2'd1,
    REG_DOUBLE = 2'd2
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam int CenterReset = 65536;
  localparam int HalfReset   = 2621;

  // Reciprocal of ten in 0.16 fixed point, good for sums below 2296.
  localparam int RecipTen = 6554;

endpackage

// ===== hdl/dbl_front.sv =====
// Front pipeline of the depth buffer linearizer: products, numerator and denominator.
// Also forms the depth and gray bytes. Depends on dbl_pkg.
module dbl_front import dbl_pkg::*; #(
  parameter int DEPTH_BITS = DefDepthBits,
  parameter int DIST_BITS  = DefDistBits,
  parameter int RW = 2 * DIST_BITS + DEPTH_BITS + 2,
  parameter int DW = DIST_BITS + DEPTH_BITS + 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [DEPTH_BITS-1:0] code,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  input  logic [DIST_BITS-1:0]  near_plane,
  input  logic [DIST_BITS:0]    far_plane,
  input  logic                  dbl,
  output logic                  v_out,
  output logic [RW-1:0]         num,
  output logic [DW-1:0]         den,
  output logic                  flag,
  output logic [7:0]            dbyte,
  output logic [7:0]            gray
);

  localparam int D  = DEPTH_BITS;
  localparam int W  = DIST_BITS;
  localparam int NF = 2 * W + 1;
  localparam logic [D-1:0] FULL = {D{1'b1}};

  logic          v1;
  logic [NF-1:0] nf1;
  logic [W+D:0]  pa1;
  logic [W+D-1:0] pb1;
  logic          flag1;
  logic [7:0]    dbyte1;
  logic [11:0]   sum1;
  logic [D+8:0]  xs;
  logic [D+8:0]  xr;
  logic [NF+D-1:0] base;
  logic [27:0]   gp;

  // Depth byte: divide 255*code by 2^D-1 with the shift-and-add identity.
  always_comb begin
    xs = (D + 9)'(code) * (D + 9)'(255);
    xr = xs + (xs >> D) + (D + 9)'(1);
  end

  // First stage: the three products, the color sum, the far flag and depth byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nf1    <= NF'(near_plane) * NF'(far_plane);
      pa1    <= (W + D + 1)'(far_plane) * (W + D + 1)'(FULL - code);
      pb1    <= (W + D)'(code) * (W + D)'(near_plane);
      flag1  <= (code == FULL);
      dbyte1 <= xr[D+7:D];
      sum1   <= 12'(red) * 12'd5 + 12'(green) * 12'd3 + 12'(blue);
    end
  end

  // Times the full-scale code is a shift and a subtract.
  always_comb begin
    base = ((NF + D)'(nf1) << D) - (NF + D)'(nf1);
    gp   = 28'(sum1) * 28'(RecipTen);
  end

  // Second stage: numerator, denominator and gray level.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num   <= dbl ? (RW'(base) << 1) : RW'(base);
      den   <= DW'(pa1) + DW'(pb1);
      flag  <= flag1;
      dbyte <= dbyte1;
      gray  <= gp[23:16];
    end
  end

endmodule

// ===== hdl/dbl_div.sv =====
// Pipelined restoring divider with saturation, one quotient bit per stage.
// Carries side data alongside the quotient. Depends on dbl_pkg.
module dbl_div import dbl_pkg::*; #(
  parameter int DIST_BITS = DefDistBits,
  parameter int RW = 2 * DIST_BITS + DefDepthBits + 2,
  parameter int DW = DIST_BITS + DefDepthBits + 2,
  parameter int SW = DIST_BITS + 17
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 v_in,
  input  logic [RW-1:0]        num,
  input  logic [DW-1:0]        den,
  input  logic [SW-1:0]        side_in,
  output logic                 v_out,
  output logic [DIST_BITS-1:0] quot,
  output logic [SW-1:0]        side_out
);

  localparam int W = DIST_BITS;

  logic [RW-1:0] rem  [0:W-1];
  logic [DW-1:0] dn   [0:W-1];
  logic [W-1:0]  q    [0:W];
  logic          done [0:W];
  logic          v    [0:W];
  logic [SW-1:0] side [0:W];
  logic          den_zero;
  logic          sat;

  // Entry stage: zero divisor gives zero, an oversized quotient saturates.
  always_comb begin
    den_zero = (den == '0);
    sat      = (num >= (RW'(den) << W));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= num;
      dn[0]   <= den;
      q[0]    <= (sat && !den_zero) ? {W{1'b1}} : '0;
      done[0] <= den_zero || sat;
      side[0] <= side_in;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = 0; s < W; s++) begin : g_stage
    localparam int B = W - 1 - s;
    logic [RW-1:0] dsh;
    logic          take;

    always_comb begin
      dsh  = RW'(dn[s]) << B;
      take = !done[s] && (rem[s] >= dsh);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q[s+1]    <= take ? (q[s] | (W'(1) << B)) : q[s];
        done[s+1] <= done[s];
        side[s+1] <= side[s];
      end
    end

    if (s < W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s+1] <= take ? (rem[s] - dsh) : rem[s];
          dn[s+1]  <= dn[s];
        end
      end
    end
  end

  assign v_out    = v[W];
  assign quot     = q[W];
  assign side_out = side[W];

  // A zero divisor at entry must yield a zero quotient.
  a_zero_den: assert property (@(posedge clk) disable iff (rst)
    (en && v_in && den == '0) |=> (q[0] == '0 && done[0]))
    else $error("zero divisor did not give zero quotient");

endmodule

// ===== hdl/depth_buffer_linearizer.sv =====
// Top level of the depth buffer linearizer.
// Instantiates dbl_front and dbl_div; depends on dbl_pkg.
//
// Converts one pixel per transfer: a normalized depth code and RGB bytes
// in, an eye-space distance (Q8.16), a far-plane flag, a depth byte and a
// gray byte out. Input and output channels use valid/ready; the
// configuration channel writes center_distance (0), half_range (1) and
// double_numerator (2) and is always ready. Unknown indexes are ignored.
// Configuration must be written only while no pixel is in flight; the block
// does not enforce it. Input is held off after a write while planes settle.
//
// Throughput is one pixel per clock unless the output stalls or a write
// holds the input off. Two front stages form the products, then come one
// divider entry stage, one stage per quotient bit and the output register.
// Reset clears all valid bits and loads the register reset values.
// When the receiver holds ready low with a result waiting, the whole
// pipeline freezes and in_ready drops; nothing is lost or repeated.
module depth_buffer_linearizer import dbl_pkg::*; #(
  parameter int DEPTH_BITS = DefDepthBits,
  parameter int DIST_BITS  = DefDistBits
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DEPTH_BITS-1:0] depth_code,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DIST_BITS-1:0]  linear_depth,
  output logic                  at_far_plane,
  output logic [7:0]            depth_byte,
  output logic [7:0]            gray_byte,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [DIST_BITS-1:0]  cfg_data
);

  localparam int D  = DEPTH_BITS;
  localparam int W  = DIST_BITS;
  localparam int RW = 2 * W + D + 2;
  localparam int DW = W + D + 2;
  localparam int SW = W + 17;

  logic [W-1:0]  center;
  logic [W-1:0]  half;
  logic          dbl;
  logic [W-1:0]  near_plane;
  logic [W:0]    far_plane;
  logic [W-1:0]  far_clamp;
  logic          cfg_wait;
  logic          en;
  logic          fv;
  logic [RW-1:0] num;
  logic [DW-1:0] den;
  logic          fflag;
  logic [7:0]    fdbyte;
  logic [7:0]    fgray;
  logic          dv;
  logic [W-1:0]  quot;
  logic [SW-1:0] dside;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center <= W'(CenterReset);
      half   <= W'(HalfReset);
      dbl    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER: center <= cfg_data;
        REG_HALF:   half   <= cfg_data;
        REG_DOUBLE: dbl    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Near and far planes, registered from the configuration.
  always_ff @(posedge clk) begin
    near_plane <= (center >= half) ? (center - half) : '0;
    far_plane  <= (W + 1)'(center) + (W + 1)'(half);
  end

  assign far_clamp = far_plane[W] ? {W{1'b1}} : far_plane[W-1:0];

  // The planes update in the cycle after a register write; hold the input meanwhile.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_wait <= 1'b0;
    end else begin
      cfg_wait <= cfg_valid && cfg_ready;
    end
  end

  // The pipeline advances unless a result is held at the output.
  assign en       = !out_valid || out_ready;
  assign in_ready = en && !cfg_wait;

  dbl_front #(
    .DEPTH_BITS(D), .DIST_BITS(W), .RW(RW), .DW(DW)
  ) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid && !cfg_wait),
    .code(depth_code),
    .red(red), .green(green), .blue(blue), .near_plane(near_plane),
    .far_plane(far_plane), .dbl(dbl), .v_out(fv), .num(num), .den(den),
    .flag(fflag), .dbyte(fdbyte), .gray(fgray)
  );

  dbl_div #(
    .DIST_BITS(W), .RW(RW), .DW(DW), .SW(SW)
  ) u_div (
    .clk(clk), .rst(rst), .en(en), .v_in(fv), .num(num), .den(den),
    .side_in({fflag, far_clamp, fdbyte, fgray}),
    .v_out(dv), .quot(quot), .side_out(dside)
  );

  // Output register; the far plane replaces the quotient for full scale.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      linear_depth <= dside[SW-1] ? dside[W+15:16] : quot;
      at_far_plane <= dside[SW-1];
      depth_byte   <= dside[15:8];
      gray_byte    <= dside[7:0];
    end
  end

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // The gray level never exceeds its maximum.
  a_gray_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> gray_byte <= 8'd229)
    else $error("gray byte out of range");

  // A far-plane result carries the clamped far distance.
  a_far_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && at_far_plane) |-> linear_depth == far_clamp)
    else $error("far-plane result does not match far distance");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the depth buffer linearizer.
// Depends on dbl_pkg and depth_buffer_linearizer; predicts untyped pixels in SystemVerilog.
`timescale 1ns / 100ps

module tb_top import dbl_pkg::*;;

  localparam int DepthBits = 24;
  localparam int DistBits  = 24;
  localparam int Latency   = DistBits + 4;
  localparam logic [DepthBits-1:0] FullCode = {DepthBits{1'b1}};
  localparam logic [DistBits-1:0]  DistMax  = {DistBits{1'b1}};

  typedef struct packed {
    logic [DepthBits-1:0] code;
    logic [7:0]           r;
    logic [7:0]           g;
    logic [7:0]           b;
  } pixel_t;

  typedef struct packed {
    logic [DistBits-1:0] lin_dist;
    logic                far_flag;
    logic [7:0]          dbyte;
    logic [7:0]          gray;
  } result_t;

  // Directed row: pixel plus an optional hand-typed result.
  typedef struct packed {
    pixel_t  pix;
    logic    typed;
    result_t res;
  } row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [DepthBits-1:0] depth_code;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic out_valid;
  logic out_ready;
  logic [DistBits-1:0] linear_depth;
  logic at_far_plane;
  logic [7:0] depth_byte;
  logic [7:0] gray_byte;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [DistBits-1:0] cfg_data;

  // Predictor copy of the configuration.
  logic [DistBits-1:0] cur_center;
  logic [DistBits-1:0] cur_half;
  logic                cur_double;

  result_t pending_pixels[$];
  int errors;
  int pixels_sent;
  int pixels_checked;
  int settings_run;
  bit hold_off;

  depth_buffer_linearizer i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .depth_code(depth_code), .red(red), .green(green), .blue(blue),
    .out_valid(out_valid), .out_ready(out_ready),
    .linear_depth(linear_depth), .at_far_plane(at_far_plane),
    .depth_byte(depth_byte), .gray_byte(gray_byte),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("Timeout at %0t", $time);
    $display("depth_buffer_linearizer: mismatch");
    $finish;
  end

  // Eye-space distance from the current planes, with saturation.
  function automatic result_t linearize(pixel_t p);
    logic [DistBits:0]   near_pl;
    logic [DistBits:0]   far_pl;
    logic [127:0]        num;
    logic [127:0]        den;
    logic [127:0]        quo;
    result_t             res;
    near_pl = (cur_center >= cur_half) ? (DistBits + 1)'(cur_center - cur_half) : '0;
    far_pl  = (DistBits + 1)'(cur_center) + (DistBits + 1)'(cur_half);
    res.far_flag = (p.code == FullCode);
    if (res.far_flag) begin
      res.lin_dist = (far_pl > (DistBits + 1)'(DistMax)) ? DistMax : far_pl[DistBits-1:0];
    end else begin
      num = 128'(near_pl) * 128'(far_pl) * 128'(FullCode);
      if (cur_double) num = num << 1;
      den = 128'(far_pl) * 128'(FullCode - p.code) + 128'(p.code) * 128'(near_pl);
      if (den == 0) begin
        res.lin_dist = '0;
      end else begin
        quo = num / den;
        res.lin_dist = (quo > 128'(DistMax)) ? DistMax : quo[DistBits-1:0];
      end
    end
    res.dbyte = 8'((64'd255 * 64'(p.code)) / 64'(FullCode));
    res.gray  = 8'((32'd5 * p.r + 32'd3 * p.g + 32'(p.b)) / 10);
    return res;
  endfunction

  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One register write; cfg_valid drops before the next write so writes never abut.
  task automatic write_reg(cfg_reg_t idx, logic [DistBits-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CENTER: cur_center = val;
      REG_HALF:   cur_half = val;
      REG_DOUBLE: cur_double = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one pixel and record its expected result at the transfer.
  task automatic send_pixel(pixel_t p, logic typed, result_t res);
    result_t exp_res;
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    exp_res = typed ? res : linearize(p);
    in_valid   <= 1'b1;
    depth_code <= p.code;
    red        <= p.r;
    green      <= p.g;
    blue       <= p.b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_pixels.push_back(exp_res);
    pixels_sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (Latency + 4) @(posedge clk);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: p.code = FullCode;
      1: p.code = FullCode - DepthBits'($urandom_range(0, 3));
      2: p.code = DepthBits'($urandom_range(0, 3));
      3: p.code = FullCode - DepthBits'($urandom_range(0, 65535));
      default: p.code = DepthBits'($urandom);
    endcase
    p.r = 8'($urandom);
    p.g = 8'($urandom);
    p.b = 8'($urandom);
    return p;
  endfunction

  // Receiver: random stalls plus one long hold-off.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    result_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result distance=%0d", $time, linear_depth);
        errors++;
      end else begin
        exp_res = pending_pixels.pop_front();
        pixels_checked++;
        if (linear_depth !== exp_res.lin_dist) begin
          $display("%0t: linear_depth expected %0d actual %0d",
                   $time, exp_res.lin_dist, linear_depth);
          errors++;
        end
        if (at_far_plane !== exp_res.far_flag) begin
          $display("%0t: at_far_plane expected %0d actual %0d",
                   $time, exp_res.far_flag, at_far_plane);
          errors++;
        end
        if (depth_byte !== exp_res.dbyte) begin
          $display("%0t: depth_byte expected %0d actual %0d",
                   $time, exp_res.dbyte, depth_byte);
          errors++;
        end
        if (gray_byte !== exp_res.gray) begin
          $display("%0t: gray_byte expected %0d actual %0d",
                   $time, exp_res.gray, gray_byte);
          errors++;
        end
      end
    end
  end

  // Long hold-off on the receiver while the sender keeps offering pixels.
  initial begin
    hold_off = 1'b0;
    wait (pixels_sent > 300);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    row_t dir_rows[$];
    row_t rw;
    pixel_t p;
    result_t none;
    logic [DistBits-1:0] centers[6];
    logic [DistBits-1:0] halves[6];
    none = '0;
    errors = 0;
    pixels_sent = 0;
    pixels_checked = 0;
    settings_run = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    depth_code = '0;
    red = '0;
    green = '0;
    blue = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_CENTER;
    cfg_data = '0;
    cur_center = DistBits'(CenterReset);
    cur_half = DistBits'(HalfReset);
    cur_double = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table at reset settings; far and byte extremes are typed in.
    dir_rows.push_back('{'{FullCode, 8'd255, 8'd255, 8'd255}, 1'b1,
                         '{DistBits'(CenterReset + HalfReset), 1'b1, 8'd255, 8'd229}});
    dir_rows.push_back('{'{24'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
                         '{DistBits'(CenterReset - HalfReset), 1'b0, 8'd0, 8'd0}});
    dir_rows.push_back('{'{24'd0, 8'd255, 8'd0, 8'd0}, 1'b0, none});
    dir_rows.push_back('{'{24'd1, 8'd0, 8'd255, 8'd0}, 1'b0, none});
    dir_rows.push_back('{'{FullCode - 24'd1, 8'd0, 8'd0, 8'd255}, 1'b0, none});
    dir_rows.push_back('{'{24'h800000, 8'h55, 8'haa, 8'h0f}, 1'b0, none});
    dir_rows.push_back('{'{24'h7fffff, 8'haa, 8'h55, 8'hf0}, 1'b0, none});
    dir_rows.push_back('{'{24'hfff000, 8'd9, 8'd1, 8'd0}, 1'b0, none});
    foreach (dir_rows[i]) begin
      rw = dir_rows[i];
      send_pixel(rw.pix, rw.typed, rw.res);
    end
    drain();

    // Corner settings: near clamped, zero planes, far overflow, doubled numerator.
    centers = '{24'd0, 24'd0, 24'hffffff, 24'h000100, 24'hffffff, 24'h123456};
    halves  = '{24'd0, 24'hffffff, 24'hffffff, 24'h000200, 24'd0, 24'h001000};
    for (int s = 0; s < 6; s++) begin
      write_reg(REG_CENTER, centers[s]);
      write_reg(REG_HALF, halves[s]);
      write_reg(REG_DOUBLE, DistBits'(s % 2));
      settings_run++;
      send_pixel('{FullCode, 8'd0, 8'd0, 8'd0}, 1'b0, none);
      send_pixel('{24'd0, 8'd255, 8'd255, 8'd255}, 1'b0, none);
      send_pixel('{FullCode - 24'd1, 8'd7, 8'd8, 8'd9}, 1'b0, none);
      for (int k = 0; k < 20; k++) send_pixel(random_pixel(), 1'b0, none);
      drain();
    end

    // Random phases with random settings, biased toward realistic ranges.
    for (int ph = 0; ph < 12; ph++) begin
      if (ph % 3 == 0) begin
        write_reg(REG_CENTER, DistBits'($urandom));
        write_reg(REG_HALF, DistBits'($urandom));
      end else begin
        write_reg(REG_CENTER, DistBits'($urandom_range(1, 24'h0fffff)));
        write_reg(REG_HALF, DistBits'($urandom_range(0, 24'h00ffff)));
      end
      write_reg(REG_DOUBLE, DistBits'($urandom_range(0, 1)));
      settings_run++;
      for (int k = 0; k < 150; k++) begin
        p = random_pixel();
        send_pixel(p, 1'b0, none);
      end
      drain();
    end

    $display("Covered %0d pixels checked over %0d register settings,",
             pixels_checked, settings_run);
    $display("including far-plane, clamped-near, zero-plane and saturation cases.");
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("depth_buffer_linearizer: match");
    end else begin
      $display("depth_buffer_linearizer: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/dbl_pkg.sv
hdl/dbl_front.sv
hdl/dbl_div.sv
hdl/depth_buffer_linearizer.sv
tb/tb_top.sv
